[design/ili_pkg.sv]
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and constants for the indexed list block: command codes,
// transfer payloads and the control word handed to every list cell.
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned PosInW   = 8;
  localparam int unsigned LenW     = 7;

  localparam int unsigned CntWDefault = $clog2(Capacity + 1);
  localparam int unsigned PosWDefault = (CntWDefault > PosInW) ? CntWDefault : PosInW;

  typedef enum logic [CmdW-1:0] {
    CmdRead   = 3'd0,
    CmdInsHd  = 3'd1,
    CmdInsTl  = 3'd2,
    CmdInsPos = 3'd3,
    CmdDelPos = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    CellHold  = 3'd0,
    CellIns   = 3'd1,
    CellDel   = 3'd2,
    CellLoad  = 3'd3,
    CellShift = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [PosInW-1:0]  position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic                    found;
    logic                    accepted;
    logic [LenW-1:0]         list_length;
  } out_item_t;

endpackage

[design/indexed_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to CAPACITY signed words held in a row of cells.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command:
// read, insert at head, insert at tail, insert at position or delete at
// position. Output channel (out_valid_o / out_stall_i / out_data_o) returns
// exactly one result per command with the list length after it.
// Insert and delete move all affected cells at once: the result is valid in
// the cycle after the input transfer. A read that hits position p walks the
// element down the read chain to cell 0, one cell per cycle; the result is
// registered from cell 0 when the walk ends. Reads that miss and ignored
// commands go straight to the result. One command is in flight at a time;
// the next input transfer is taken the cycle after the result transfer.
// Reset empties the list. While out_stall_i is high the result is held and
// in_stall_o stays high.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ili_pkg::Capacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ili_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ili_pkg::out_item_t out_data_o
);
  import ili_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > PosInW) ? CntW : PosInW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StShift = 3'b010,
    StResp  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] walk_q, walk_d;
  out_item_t       out_q, out_d;

  cell_ctrl_t      ctrl;
  logic [PosW-1:0] cell_pos;
  logic [PosW-1:0] pos_ext, cnt_ext;
  logic            take, full, in_range, in_reach;

  logic [DataW-1:0] data_w [CAPACITY];
  logic [DataW-1:0] rd_w   [CAPACITY];

  assign take     = in_valid_i && !in_stall_o;
  assign pos_ext  = PosW'(in_data_i.position);
  assign cnt_ext  = PosW'(cnt_q);
  assign full     = (cnt_q == CntW'(CAPACITY));
  assign in_range = (pos_ext < cnt_ext);
  assign in_reach = (pos_ext <= cnt_ext);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    walk_d     = walk_q;
    out_d      = out_q;
    ctrl.op    = CellHold;
    ctrl.value = in_data_i.value;
    cell_pos   = pos_ext;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          out_d.read_value = '1;
          out_d.found      = 1'b0;
          out_d.accepted   = 1'b0;
          state_d          = StResp;
          unique case (in_data_i.command) inside
            CmdRead: begin
              if (in_range) begin
                ctrl.op        = CellLoad;
                out_d.found    = 1'b1;
                out_d.accepted = 1'b1;
                walk_d         = pos_ext;
                state_d        = StShift;
              end
            end
            CmdInsHd, CmdInsTl, CmdInsPos: begin
              if (!full && (in_data_i.command != CmdInsPos || in_reach)) begin
                ctrl.op        = CellIns;
                out_d.accepted = 1'b1;
                cnt_d          = cnt_q + CntW'(1);
                if (in_data_i.command == CmdInsHd) begin
                  cell_pos = '0;
                end else if (in_data_i.command == CmdInsTl) begin
                  cell_pos = cnt_ext;
                end
              end
            end
            CmdDelPos: begin
              if (in_range) begin
                ctrl.op        = CellDel;
                out_d.accepted = 1'b1;
                cnt_d          = cnt_q - CntW'(1);
              end
            end
            default: ;
          endcase
          out_d.list_length = LenW'(cnt_d);
        end
      end
      StShift: begin
        if (walk_q == '0) begin
          out_d.read_value = rd_w[0];
          state_d          = StResp;
        end else begin
          ctrl.op = CellShift;
          walk_d  = walk_q - PosW'(1);
        end
      end
      StResp: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PosW-1:0] Idx = PosW'(i);
    logic [DataW-1:0] left_w, right_w, rd_right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w    = '0;
      assign rd_right_w = '0;
    end else begin : g_body
      assign right_w    = data_w[i+1];
      assign rd_right_w = rd_w[i+1];
    end
    ili_cell #(
      .PosW(PosW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pos_i     (cell_pos),
      .idx_i     (Idx),
      .left_i    (left_w),
      .right_i   (right_w),
      .rd_right_i(rd_right_w),
      .data_o    (data_w[i]),
      .rd_o      (rd_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StResp);
  assign out_data_o  = out_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> in_stall_o)
    else $error("input taken while a command is in flight");

  a_found_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> out_data_o.accepted)
    else $error("read hit without accepted");

  a_miss_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.read_value == '1))
    else $error("read_value not all ones on a miss");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("element count beyond capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(cnt_q))
    else $error("element count changed without a command");

endmodule

[design/ili_cell.sv]
// ----------------------------------------------------------------------------
// ili_cell
// One list slot. Holds one element and one read-chain stage; shifts data
// with its neighbors on insert, delete and read-out.
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int unsigned PosW = ili_pkg::PosWDefault
) (
  input  logic                    clk_i,
  input  ili_pkg::cell_ctrl_t     ctrl_i,
  input  logic [PosW-1:0]         pos_i,
  input  logic [PosW-1:0]         idx_i,
  input  logic [ili_pkg::DataW-1:0] left_i,
  input  logic [ili_pkg::DataW-1:0] right_i,
  input  logic [ili_pkg::DataW-1:0] rd_right_i,
  output logic [ili_pkg::DataW-1:0] data_o,
  output logic [ili_pkg::DataW-1:0] rd_o
);
  import ili_pkg::*;

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic             is_pos, above_pos;

  assign is_pos    = (idx_i == pos_i);
  assign above_pos = (idx_i > pos_i);

  always_comb begin
    data_d = data_q;
    rd_d   = rd_q;
    unique case (ctrl_i.op)
      CellHold: ;
      CellIns: begin
        if (above_pos) begin
          data_d = left_i;
        end else if (is_pos) begin
          data_d = ctrl_i.value;
        end
      end
      CellDel: begin
        if (above_pos || is_pos) begin
          data_d = right_i;
        end
      end
      CellLoad: begin
        rd_d = is_pos ? data_q : '0;
      end
      CellShift: begin
        rd_d = rd_right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule
